@@ hw/rtl/quad_motor_mixer_packer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the quad motor mixer and packer
// Shared property shapes, clocked on the rising edge, off while in reset.
// ----------------------------------------------------------------------------
`ifndef QUAD_MOTOR_MIXER_PACKER_ASSERT_SVH
`define QUAD_MOTOR_MIXER_PACKER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define QMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("quad motor mixer: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define QMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("quad motor mixer: next-cycle check failed");

`endif

@@ hw/rtl/qmm_pkg.sv @@
// ----------------------------------------------------------------------------
// qmm_pkg
// Widths, indexes, divider types and helpers for the quad motor mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package qmm_pkg;

	// Fixed point format of the attitude and thrust commands
	localparam int FRAC_BITS = 14;
	localparam int SHIFT     = FRAC_BITS + 1;

	// Field widths
	localparam int CMD_W  = 16;
	localparam int THR_W  = 15;
	localparam int GAS_W  = 9;
	localparam int PKT_W  = 40;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Internal arithmetic widths
	localparam int Q_W     = CMD_W;             // quotient bits of the attitude scaler
	localparam int NUM_W   = CMD_W + THR_W;     // |cmd| * thrust
	localparam int MIX_W   = 20;                // mixed motor value, doubled scale
	localparam int DIFF_W  = GAS_W + 1;         // gas_max - gas_min, signed
	localparam int PROD_W  = MIX_W + DIFF_W;
	localparam int CODE_W  = PROD_W - SHIFT + 2;

	// Lanes and motors
	localparam int AXES    = 3;
	localparam int AX_ROLL  = 0;
	localparam int AX_PITCH = 1;
	localparam int AX_YAW   = 2;

	localparam int MOTORS  = 4;
	localparam int M_FRONT = 0;
	localparam int M_RIGHT = 1;
	localparam int M_BACK  = 2;
	localparam int M_LEFT  = 3;

	localparam logic [2:0] PKT_HDR  = 3'b001;
	localparam logic       PKT_TAIL = 1'b0;

	// Register reset values
	localparam logic [THR_W-1:0] FULL_CONTROL_START_RST = THR_W'(4096);
	localparam logic [THR_W-1:0] THRUST_CEILING_RST     = THR_W'(16384);
	localparam logic [GAS_W-1:0] GAS_MIN_RST            = GAS_W'(10);
	localparam logic [GAS_W-1:0] GAS_MAX_RST            = GAS_W'(510);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FULL_CONTROL_START = CFG_IDX_W'(0),
		CFG_THRUST_CEILING     = CFG_IDX_W'(1),
		CFG_GAS_MIN            = CFG_IDX_W'(2),
		CFG_GAS_MAX            = CFG_IDX_W'(3)
	} cfg_reg_t;

	// One lane of the restoring divider
	typedef struct packed {
		logic [THR_W-1:0] rem;
		logic [Q_W-1:0]   nlow;
		logic [Q_W-1:0]   q;
	} div_lane_t;

	// Everything that travels through one divider stage
	typedef struct packed {
		div_lane_t [AXES-1:0]           lane;
		logic [AXES-1:0]                neg;
		logic [AXES-1:0][CMD_W-1:0]     cmd;
		logic [THR_W-1:0]               thrust;
		logic                           scale;
	} div_stage_t;

	// One quotient bit: shift in the next numerator bit, subtract when it fits
	function automatic div_lane_t div_step(div_lane_t cur, logic [THR_W-1:0] den);
		logic [THR_W:0] trial;
		logic [THR_W:0] diff;
		logic           ge;
		div_lane_t      nxt;
		trial    = {cur.rem, cur.nlow[Q_W-1]};
		diff     = trial - {1'b0, den};
		ge       = (trial >= {1'b0, den});
		nxt.rem  = ge ? diff[THR_W-1:0] : trial[THR_W-1:0];
		nxt.nlow = {cur.nlow[Q_W-2:0], 1'b0};
		nxt.q    = {cur.q[Q_W-2:0], ge};
		return nxt;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qmm_if.sv @@
// ----------------------------------------------------------------------------
// qmm channel interfaces
// Command, motor result and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface qmm_cmd_if import qmm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CMD_W-1:0] roll_cmd;
	logic signed [CMD_W-1:0] pitch_cmd;
	logic signed [CMD_W-1:0] yaw_cmd;
	logic [THR_W-1:0]        thrust_cmd;

	modport source (output valid, output roll_cmd, output pitch_cmd, output yaw_cmd,
		output thrust_cmd, input ready);
	modport sink (input valid, input roll_cmd, input pitch_cmd, input yaw_cmd,
		input thrust_cmd, output ready);
endinterface

interface qmm_motor_if import qmm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [GAS_W-1:0] motor_front;
	logic [GAS_W-1:0] motor_right;
	logic [GAS_W-1:0] motor_back;
	logic [GAS_W-1:0] motor_left;
	logic [PKT_W-1:0] packet_word;

	modport source (output valid, output motor_front, output motor_right,
		output motor_back, output motor_left, output packet_word, input ready);
	modport sink (input valid, input motor_front, input motor_right,
		input motor_back, input motor_left, input packet_word, output ready);
endinterface

interface qmm_cfg_if import qmm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/quad_motor_mixer_packer.sv @@
// ----------------------------------------------------------------------------
// quad_motor_mixer_packer
// X-frame motor mixer: attitude scaling at low thrust, mixing, ceiling limit,
// motor code mapping and packing into a five-byte command word.
// ----------------------------------------------------------------------------
//  channel  | role   | handshake   | payload
//  cmd      | sink   | valid/ready | roll_cmd, pitch_cmd, yaw_cmd, thrust_cmd
//  motor    | source | valid/ready | motor_front/right/back/left, packet_word
//  cfg      | sink   | valid/ready | index, data (always ready)
//
//  One item per cycle while no result waits at the output. The pipe holds the
//  attitude scaler, a restoring divider with one quotient bit per stage
//  (16 stages), plus seven arithmetic stages.
//  Reset clears all valid bits and loads the register defaults.
//  The whole pipe holds while a result waits at the output; cmd.ready drops
//  only then.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_motor_mixer_packer import qmm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	qmm_cmd_if.sink      cmd,
	qmm_motor_if.source  motor,
	qmm_cfg_if.sink      cfg
);

	`include "quad_motor_mixer_packer_assert.svh"

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [THR_W-1:0] full_control_start_q;
	logic [THR_W-1:0] thrust_ceiling_q;
	logic [GAS_W-1:0] gas_min_q;
	logic [GAS_W-1:0] gas_max_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_control_start_q <= FULL_CONTROL_START_RST;
			thrust_ceiling_q     <= THRUST_CEILING_RST;
			gas_min_q            <= GAS_MIN_RST;
			gas_max_q            <= GAS_MAX_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_FULL_CONTROL_START: full_control_start_q <= cfg.data[THR_W-1:0];
				CFG_THRUST_CEILING:     thrust_ceiling_q     <= cfg.data[THR_W-1:0];
				CFG_GAS_MIN:            gas_min_q            <= cfg.data[GAS_W-1:0];
				CFG_GAS_MAX:            gas_max_q            <= cfg.data[GAS_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: every stage advances together
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [Q_W-1:0] div_vld_s;
	logic adv;

	assign adv       = !vld_s7 || motor.ready;
	assign cmd.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			div_vld_s <= '0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
		end else if (adv) begin
			vld_s1    <= cmd.valid;
			vld_s2    <= vld_s1;
			div_vld_s <= {div_vld_s[Q_W-2:0], vld_s2};
			vld_s3    <= div_vld_s[Q_W-1];
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture, magnitudes, scaling decision
	// ------------------------------------------------------------------
	logic [AXES-1:0][CMD_W-1:0] cmd_in;
	logic [AXES-1:0][CMD_W-1:0] cmd_s1;
	logic [AXES-1:0][CMD_W-1:0] mag_s1;
	logic [AXES-1:0]            neg_s1;
	logic [THR_W-1:0]           thrust_s1;
	logic                       scale_s1;

	assign cmd_in[AX_ROLL]  = cmd.roll_cmd;
	assign cmd_in[AX_PITCH] = cmd.pitch_cmd;
	assign cmd_in[AX_YAW]   = cmd.yaw_cmd;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				cmd_s1[a] <= cmd_in[a];
				neg_s1[a] <= cmd_in[a][CMD_W-1];
				mag_s1[a] <= cmd_in[a][CMD_W-1] ? (~cmd_in[a] + CMD_W'(1)) : cmd_in[a];
			end
			thrust_s1 <= cmd.thrust_cmd;
			scale_s1  <= (cmd.thrust_cmd < full_control_start_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: numerators |cmd| * thrust
	// ------------------------------------------------------------------
	logic [AXES-1:0][NUM_W-1:0] num_s2;
	logic [AXES-1:0][CMD_W-1:0] cmd_s2;
	logic [AXES-1:0]            neg_s2;
	logic [THR_W-1:0]           thrust_s2;
	logic                       scale_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				num_s2[a] <= NUM_W'(mag_s1[a]) * NUM_W'(thrust_s1);
			end
			cmd_s2    <= cmd_s1;
			neg_s2    <= neg_s1;
			thrust_s2 <= thrust_s1;
			scale_s2  <= scale_s1;
		end
	end

	// ------------------------------------------------------------------
	// Divider: one quotient bit per stage, three lanes side by side
	// ------------------------------------------------------------------
	div_stage_t div_entry;
	div_stage_t div_s [Q_W];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			// thrust below the start point keeps the quotient under 2^Q_W
			div_entry.lane[a].rem  = num_s2[a][NUM_W-1:Q_W];
			div_entry.lane[a].nlow = num_s2[a][Q_W-1:0];
			div_entry.lane[a].q    = '0;
		end
		div_entry.neg    = neg_s2;
		div_entry.cmd    = cmd_s2;
		div_entry.thrust = thrust_s2;
		div_entry.scale  = scale_s2;
	end

	for (genvar d = 0; d < Q_W; d++) begin : g_div
		div_stage_t cur;
		div_stage_t nxt;

		if (d == 0) begin : g_first
			assign cur = div_entry;
		end else begin : g_rest
			assign cur = div_s[d-1];
		end

		always_comb begin
			nxt = cur;
			for (int a = 0; a < AXES; a++) begin
				nxt.lane[a] = div_step(cur.lane[a], full_control_start_q);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[d] <= nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: signed attitude and mixing at doubled scale
	// ------------------------------------------------------------------
	div_stage_t div_out;
	logic signed [CMD_W-1:0] att [AXES];
	logic signed [MIX_W-1:0] mr, mp, my2, mt2;
	logic signed [MIX_W-1:0] mix_d [MOTORS];
	logic signed [MIX_W-1:0] m_s3 [MOTORS];

	assign div_out = div_s[Q_W-1];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			if (!div_out.scale) begin
				att[a] = signed'(div_out.cmd[a]);
			end else if (div_out.neg[a]) begin
				att[a] = signed'(~div_out.lane[a].q + CMD_W'(1));
			end else begin
				att[a] = signed'(div_out.lane[a].q);
			end
		end
		mr  = MIX_W'(att[AX_ROLL]);
		mp  = MIX_W'(att[AX_PITCH]);
		my2 = MIX_W'(att[AX_YAW]) <<< 1;
		mt2 = signed'(MIX_W'({div_out.thrust, 1'b0}));
		mix_d[M_FRONT] = mt2 + mr + mp - my2;
		mix_d[M_RIGHT] = mt2 - mr + mp + my2;
		mix_d[M_BACK]  = mt2 - mr - mp - my2;
		mix_d[M_LEFT]  = mt2 + mr - mp + my2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3 <= mix_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: largest motor value
	// ------------------------------------------------------------------
	logic signed [MIX_W-1:0] mx_a, mx_b;
	logic signed [MIX_W-1:0] mx_s4;
	logic signed [MIX_W-1:0] m_s4 [MOTORS];

	always_comb begin
		mx_a = (m_s3[M_RIGHT] > m_s3[M_FRONT]) ? m_s3[M_RIGHT] : m_s3[M_FRONT];
		mx_b = (m_s3[M_LEFT] > m_s3[M_BACK]) ? m_s3[M_LEFT] : m_s3[M_BACK];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s4 <= (mx_b > mx_a) ? mx_b : mx_a;
			m_s4  <= m_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: pull all four down by the excess over the ceiling
	// ------------------------------------------------------------------
	logic signed [MIX_W-1:0] excess;
	logic signed [MIX_W-1:0] m_s5 [MOTORS];

	assign excess = mx_s4 - signed'(MIX_W'({thrust_ceiling_q, 1'b0}));

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int mo = 0; mo < MOTORS; mo++) begin
				m_s5[mo] <= (excess > 0) ? (m_s4[mo] - excess) : m_s4[mo];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: scale by the gas span
	// ------------------------------------------------------------------
	logic signed [DIFF_W-1:0] gdiff;
	logic signed [PROD_W-1:0] p_s6 [MOTORS];

	assign gdiff = signed'({1'b0, gas_max_q}) - signed'({1'b0, gas_min_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int mo = 0; mo < MOTORS; mo++) begin
				p_s6[mo] <= PROD_W'(m_s5[mo]) * PROD_W'(gdiff);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: floor, offset, clamp, pack
	// ------------------------------------------------------------------
	logic signed [PROD_W-1:0] shv  [MOTORS];
	logic signed [CODE_W-1:0] cv   [MOTORS];
	logic signed [CODE_W-1:0] cg   [MOTORS];
	logic [GAS_W-1:0]         code_d [MOTORS];
	logic signed [CODE_W-1:0] gmin_x, gmax_x;
	logic [GAS_W-1:0]         code_s7 [MOTORS];
	logic [PKT_W-1:0]         pkt_s7;

	assign gmin_x = signed'(CODE_W'(gas_min_q));
	assign gmax_x = signed'(CODE_W'(gas_max_q));

	always_comb begin
		for (int mo = 0; mo < MOTORS; mo++) begin
			shv[mo] = p_s6[mo] >>> SHIFT;
			cv[mo]  = CODE_W'(shv[mo]) + gmin_x;
			// non-positive codes fall back to gas_min, then clamp at gas_max
			cg[mo]  = (cv[mo] <= 0) ? gmin_x : cv[mo];
			code_d[mo] = (cg[mo] > gmax_x) ? gas_max_q : cg[mo][GAS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s7 <= code_d;
			pkt_s7  <= {PKT_HDR, code_d[M_FRONT], code_d[M_RIGHT], code_d[M_BACK],
				code_d[M_LEFT], PKT_TAIL};
		end
	end

	assign motor.valid       = vld_s7;
	assign motor.motor_front = code_s7[M_FRONT];
	assign motor.motor_right = code_s7[M_RIGHT];
	assign motor.motor_back  = code_s7[M_BACK];
	assign motor.motor_left  = code_s7[M_LEFT];
	assign motor.packet_word = pkt_s7;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	logic [Q_W+6:0] vld_all;
	logic           pkt_ok;

	assign vld_all = {vld_s1, vld_s2, div_vld_s, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7};
	assign pkt_ok  = (pkt_s7[PKT_W-1:PKT_W-3] == PKT_HDR) && (pkt_s7[0] == PKT_TAIL)
		&& (pkt_s7[36:28] == code_s7[M_FRONT]) && (pkt_s7[9:1] == code_s7[M_LEFT]);

	`QMM_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, !adv, $stable(vld_all))
	`QMM_ASSERT_NEXT(a_divider_entry, clk, arst_n, adv && vld_s2, div_vld_s[0])
	`QMM_ASSERT_SAME(a_packet_frame, clk, arst_n, motor.valid, pkt_ok)

endmodule

`default_nettype wire

@@ dv/quad_motor_mixer_packer_tb.sv @@
// ----------------------------------------------------------------------------
// quad_motor_mixer_packer_tb
// Drives roll/pitch/yaw/thrust commands through the X-frame mixer under bursty
// input and a stalling motor sink, and checks every motor code and packed
// command word against a cycle-free mixer model or hand-checked rows. A short
// directed table precedes random commands across several register settings.
// ----------------------------------------------------------------------------

module quad_motor_mixer_packer_tb import qmm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_DIR      = 17;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 100;
	localparam int DRAIN_PAD    = 30;
	localparam int IDLE_LIMIT   = 5000;

	typedef struct {
		logic signed [CMD_W-1:0] roll;
		logic signed [CMD_W-1:0] pitch;
		logic signed [CMD_W-1:0] yaw;
		logic [THR_W-1:0]        thrust;
	} mix_cmd_t;

	typedef struct {
		logic [GAS_W-1:0] front;
		logic [GAS_W-1:0] right;
		logic [GAS_W-1:0] back;
		logic [GAS_W-1:0] left;
		logic [PKT_W-1:0] pkt;
	} motor_codes_t;

	typedef struct {
		mix_cmd_t         cmd;
		bit               typed;
		logic [GAS_W-1:0] front;
		logic [GAS_W-1:0] right;
		logic [GAS_W-1:0] back;
		logic [GAS_W-1:0] left;
	} dir_row_t;

	logic clk;
	logic arst_n;

	qmm_cmd_if   cmd_ch ();
	qmm_motor_if mot_ch ();
	qmm_cfg_if   cfg_ch ();

	quad_motor_mixer_packer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.motor  (mot_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the register file
	logic [THR_W-1:0] full_ctl_start;
	logic [THR_W-1:0] ceiling;
	logic [GAS_W-1:0] gas_lo;
	logic [GAS_W-1:0] gas_hi;

	motor_codes_t motor_due_q [$];
	motor_codes_t due;
	int           mismatches  = 0;
	int           idle_cycles = 0;

	int tx_burst  = 0;
	bit tx_steady = 1'b0;

	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;

	// Hand-checked rows at reset settings; typed = 0 rows go through the model
	dir_row_t dir_tab [NUM_DIR] = '{
		'{'{16'sd0, 16'sd0, 16'sd0, 15'd0}, 1'b1, 9'd10, 9'd10, 9'd10, 9'd10},
		'{'{16'sd0, 16'sd0, 16'sd0, 15'd16384}, 1'b1, 9'd510, 9'd510, 9'd510, 9'd510},
		'{'{16'sd0, 16'sd0, 16'sd0, 15'd32767}, 1'b1, 9'd510, 9'd510, 9'd510, 9'd510},
		'{'{16'sh8000, 16'sd0, 16'sd0, 15'd4096}, 1'b1, 9'd10, 9'd510, 9'd510, 9'd10},
		'{'{16'sh7FFF, 16'sd0, 16'sd0, 15'd16384}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'sd0, 16'sh7FFF, 16'sd0, 15'd16384}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'sd0, 16'sh8000, 16'sd0, 15'd8192}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'sd0, 16'sd0, 16'sh7FFF, 15'd8192}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'sd0, 16'sd0, 16'sh8000, 15'd8192}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'd2048}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'sh8000, 16'sh8000, 16'sh8000, 15'd1}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		// front lands exactly on code zero
		'{'{-16'sd8847, 16'sd0, 16'sd0, 15'd4096}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 15'd4095}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'sd12345, -16'sd23456, 16'sd3210, 15'd4000}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'sd16384, 16'sd16384, 16'sd0, 15'd16384}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'sh5555, 16'shAAAA, 16'sh5555, 15'h2AAA}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{'{16'shAAAA, 16'sh5555, 16'shAAAA, 15'h5555}, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0}
	};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic motor_codes_t pack_codes(logic [GAS_W-1:0] f, logic [GAS_W-1:0] r,
			logic [GAS_W-1:0] b, logic [GAS_W-1:0] l);
		motor_codes_t mc;
		mc.front = f;
		mc.right = r;
		mc.back  = b;
		mc.left  = l;
		mc.pkt   = {PKT_HDR, f, r, b, l, PKT_TAIL};
		return mc;
	endfunction

	// Map a doubled-scale motor value onto the gas range, floor then clamp
	function automatic logic [GAS_W-1:0] gas_code(longint m);
		longint lo;
		longint hi;
		longint c;
		lo = longint'(gas_lo);
		hi = longint'(gas_hi);
		c  = ((m * (hi - lo)) >>> SHIFT) + lo;
		if (c <= 0)
			c = lo;
		if (c > hi)
			c = hi;
		return GAS_W'(c);
	endfunction

	function automatic motor_codes_t mix_predict(mix_cmd_t c);
		longint ax [AXES];
		longint m [MOTORS];
		longint t;
		longint s;
		longint mx;
		longint over;
		ax[AX_ROLL]  = longint'(c.roll);
		ax[AX_PITCH] = longint'(c.pitch);
		ax[AX_YAW]   = longint'(c.yaw);
		t = longint'(c.thrust);
		s = longint'(full_ctl_start);
		// scale attitude down at low thrust, truncating toward zero
		if (t < s)
			for (int i = 0; i < AXES; i++)
				ax[i] = (ax[i] * t) / s;
		m[M_FRONT] = 2 * t + ax[AX_ROLL] + ax[AX_PITCH] - 2 * ax[AX_YAW];
		m[M_RIGHT] = 2 * t - ax[AX_ROLL] + ax[AX_PITCH] + 2 * ax[AX_YAW];
		m[M_BACK]  = 2 * t - ax[AX_ROLL] - ax[AX_PITCH] - 2 * ax[AX_YAW];
		m[M_LEFT]  = 2 * t + ax[AX_ROLL] - ax[AX_PITCH] + 2 * ax[AX_YAW];
		mx = m[0];
		for (int i = 1; i < MOTORS; i++)
			if (m[i] > mx)
				mx = m[i];
		over = mx - 2 * longint'(ceiling);
		if (over > 0)
			for (int i = 0; i < MOTORS; i++)
				m[i] -= over;
		return pack_codes(gas_code(m[M_FRONT]), gas_code(m[M_RIGHT]),
			gas_code(m[M_BACK]), gas_code(m[M_LEFT]));
	endfunction

	function automatic logic signed [CMD_W-1:0] pick_axis();
		int sel;
		sel = $urandom_range(0, 19);
		case (sel)
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sd0;
			3, 4, 5, 6: return CMD_W'($urandom);
			default: return CMD_W'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic mix_cmd_t rand_cmd();
		mix_cmd_t c;
		int sel;
		c.roll  = pick_axis();
		c.pitch = pick_axis();
		c.yaw   = pick_axis();
		sel = $urandom_range(0, 3);
		if (sel == 0 && full_ctl_start != 0)
			c.thrust = THR_W'($urandom_range(0, int'(full_ctl_start) - 1));
		else if (sel == 3)
			c.thrust = THR_W'($urandom);
		else
			c.thrust = THR_W'($urandom_range(0, 16384));
		return c;
	endfunction

	task automatic send_cmd(mix_cmd_t c, motor_codes_t want);
		if (!tx_steady && tx_burst == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			tx_burst = $urandom_range(1, 40);
		end
		if (tx_burst > 0)
			tx_burst--;
		cmd_ch.valid      <= 1'b1;
		cmd_ch.roll_cmd   <= c.roll;
		cmd_ch.pitch_cmd  <= c.pitch;
		cmd_ch.yaw_cmd    <= c.yaw;
		cmd_ch.thrust_cmd <= c.thrust;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		motor_due_q.push_back(want);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] dat);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= dat;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			CFG_FULL_CONTROL_START: full_ctl_start = dat[THR_W-1:0];
			CFG_THRUST_CEILING:     ceiling        = dat[THR_W-1:0];
			CFG_GAS_MIN:            gas_lo         = dat[GAS_W-1:0];
			CFG_GAS_MAX:            gas_hi         = dat[GAS_W-1:0];
			default: ;
		endcase
	endtask

	// Write all four registers with junk in the unused upper bits, then a stray index
	task automatic load_settings(logic [THR_W-1:0] fcs, logic [THR_W-1:0] ceil_v,
			logic [GAS_W-1:0] lo, logic [GAS_W-1:0] hi);
		cfg_write(CFG_FULL_CONTROL_START, {1'($urandom), fcs});
		cfg_write(CFG_THRUST_CEILING, {1'($urandom), ceil_v});
		cfg_write(CFG_GAS_MIN, {7'($urandom), lo});
		cfg_write(CFG_GAS_MAX, {7'($urandom), hi});
		cfg_write(CFG_IDX_W'($urandom_range(int'(CFG_GAS_MAX) + 1, (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		wait (motor_due_q.size() == 0);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic check_field(string fld, logic [PKT_W-1:0] want, logic [PKT_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected 0x%0h got 0x%0h", $time, fld, want, got);
			mismatches++;
		end
	endtask

	// Motor sink: pick a new random stall style each time the current run count expires
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(32, 256);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: mot_ch.ready <= 1'b1;
			1: mot_ch.ready <= 1'($urandom_range(0, 1));
			2: mot_ch.ready <= (rx_tick % 5) != 0;
			default: mot_ch.ready <= $urandom_range(0, 9) < 2;
		endcase
	end

	always @(posedge clk) begin
		if (mot_ch.valid && mot_ch.ready) begin
			if (motor_due_q.size() == 0) begin
				$display("%0t ns: motor item with nothing expected, pkt 0x%0h",
					$time, mot_ch.packet_word);
				mismatches++;
			end else begin
				due = motor_due_q.pop_front();
				check_field("motor_front", PKT_W'(due.front), PKT_W'(mot_ch.motor_front));
				check_field("motor_right", PKT_W'(due.right), PKT_W'(mot_ch.motor_right));
				check_field("motor_back", PKT_W'(due.back), PKT_W'(mot_ch.motor_back));
				check_field("motor_left", PKT_W'(due.left), PKT_W'(mot_ch.motor_left));
				check_field("packet_word", due.pkt, mot_ch.packet_word);
			end
		end
	end

	// Stop a hung run: count cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (mot_ch.valid && mot_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles, %0d items outstanding",
				$time, idle_cycles, motor_due_q.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		mix_cmd_t c;
		logic [THR_W-1:0] fcs;
		logic [THR_W-1:0] ceil_v;
		logic [GAS_W-1:0] lo;
		logic [GAS_W-1:0] hi;

		clk               = 1'b0;
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.roll_cmd   = '0;
		cmd_ch.pitch_cmd  = '0;
		cmd_ch.yaw_cmd    = '0;
		cmd_ch.thrust_cmd = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = '0;
		cfg_ch.data       = '0;
		mot_ch.ready      = 1'b0;

		full_ctl_start = FULL_CONTROL_START_RST;
		ceiling        = THRUST_CEILING_RST;
		gas_lo         = GAS_MIN_RST;
		gas_hi         = GAS_MAX_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++) begin
			if (dir_tab[i].typed)
				send_cmd(dir_tab[i].cmd, pack_codes(dir_tab[i].front, dir_tab[i].right,
					dir_tab[i].back, dir_tab[i].left));
			else
				send_cmd(dir_tab[i].cmd, mix_predict(dir_tab[i].cmd));
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					fcs = '0; ceil_v = 15'd32767; lo = '0; hi = 9'd511;
				end
				1: begin
					fcs = 15'd1; ceil_v = 15'd1; lo = 9'd511; hi = '0;
				end
				2: begin
					fcs = 15'd32767; ceil_v = '0; lo = 9'd10; hi = 9'd510;
				end
				default: begin
					case ($urandom_range(0, 5))
						0: fcs = '0;
						1: fcs = 15'd1;
						2: fcs = 15'd16384;
						3: fcs = 15'd32767;
						default: fcs = THR_W'($urandom_range(1, 16384));
					endcase
					case ($urandom_range(0, 5))
						0: ceil_v = '0;
						1: ceil_v = 15'd1;
						2: ceil_v = 15'd32767;
						3: ceil_v = 15'd16384;
						default: ceil_v = THR_W'($urandom_range(1, 32767));
					endcase
					lo = GAS_W'($urandom);
					hi = GAS_W'($urandom);
					case ($urandom_range(0, 4))
						0: begin
							lo = '0; hi = 9'd511;
						end
						1: begin
							lo = 9'd511; hi = '0;
						end
						2: hi = lo;
						default: ;
					endcase
				end
			endcase
			load_settings(fcs, ceil_v, lo, hi);
			tx_steady = (ph % 4) == 3;
			repeat (PHASE_ITEMS) begin
				c = rand_cmd();
				send_cmd(c, mix_predict(c));
			end
		end

		drain();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
